// ===== hw/rtl/fwsr_pkg.sv =====
package fwsr_pkg;

	localparam int CHANNELS       = 4;
	localparam int COUNT_BITS_DEF = 12;
	localparam int SP_W           = 8;
	localparam int GAIN_W         = 16;
	localparam int GAIN_SUM_W     = GAIN_W + 2;
	localparam int DUTY_W         = 10;
	localparam int Q_FRAC         = 8;
	localparam int GAIN_DIVISOR   = 25;
	localparam int PIPE_STAGES    = 5;
	localparam int REG_IDX_W      = 3;
	localparam int CFG_DATA_W     = GAIN_W;

	localparam logic [DUTY_W-1:0] PWM_TOP = DUTY_W'(1023);

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_SP_LEFT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SP_RIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KP       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KI       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KD       = 3'd4;

	localparam logic [SP_W-1:0]   SP_LEFT_RST  = 8'd10;
	localparam logic [SP_W-1:0]   SP_RIGHT_RST = 8'd10;
	localparam logic [GAIN_W-1:0] KP_RST       = 16'd3584;
	localparam logic [GAIN_W-1:0] KI_RST       = 16'd1562;
	localparam logic [GAIN_W-1:0] KD_RST       = 16'd141;

	// ld[0] takes an item into stage 1, ld[k] moves stage k into stage k+1
	typedef struct packed {
		logic [PIPE_STAGES-1:0] ld;
		logic                   fire;
		logic                   upd;
	} pipe_ctl_t;

endpackage

// ===== hw/rtl/fwsr_lane.sv =====
module fwsr_lane #(
	parameter int COUNT_BITS = fwsr_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fwsr_pkg::pipe_ctl_t                 ctl,
	input  logic                                pulse,
	input  logic                                tick,
	input  logic [fwsr_pkg::SP_W-1:0]           setpoint,
	input  logic [fwsr_pkg::GAIN_SUM_W-1:0]     gain_sum,
	output logic [fwsr_pkg::DUTY_W-1:0]         duty_next
);

	localparam int EW = COUNT_BITS + 1;
	localparam int PW = EW + fwsr_pkg::GAIN_SUM_W;
	localparam int MW = PW - fwsr_pkg::Q_FRAC;
	localparam int DW = MW + 2;
	localparam longint unsigned RECIP_L = (longint'(1) << MW) / fwsr_pkg::GAIN_DIVISOR;
	localparam logic [MW:0] RECIP = (MW+1)'(RECIP_L);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0]         count_q;
	logic [COUNT_BITS-1:0]         count_inc;
	logic signed [EW-1:0]          err;
	logic signed [EW-1:0]          err_s1;
	logic signed [PW:0]            prod_full;
	logic signed [PW-1:0]          prod_s2;
	logic [MW-1:0]                 xh;
	logic [MW-1:0]                 mag;
	logic [MW-1:0]                 mag_s3;
	logic                          neg_s3;
	logic [2*MW:0]                 qprod_s4;
	logic [MW-1:0]                 mag_s4;
	logic                          neg_s4;
	logic [MW-1:0]                 q0;
	logic [MW-1:0]                 rem;
	logic [MW-1:0]                 quo;
	logic signed [MW:0]            delta_s5;
	logic signed [DW-1:0]          sum;
	logic [fwsr_pkg::DUTY_W-1:0]   duty_q;

	assign count_inc = (pulse && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign err = $signed({{(EW-fwsr_pkg::SP_W){1'b0}}, setpoint}) - $signed({1'b0, count_inc});

	// clear the count on a tick, after this item's edge was counted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ld[0]) begin
			count_q <= tick ? '0 : count_inc;
		end
	end

	assign prod_full = err_s1 * $signed({1'b0, gain_sum});

	// floor of a negative quotient: -floor((-x + d - 1) / d), and -x + d - 1 = ~x + d
	assign xh  = prod_s2[PW-1:fwsr_pkg::Q_FRAC];
	assign mag = prod_s2[PW-1] ? (~xh + MW'(fwsr_pkg::GAIN_DIVISOR)) : xh;

	// reciprocal estimate is low by at most one
	assign q0  = qprod_s4[2*MW-1:MW];
	assign rem = mag_s4 - MW'(q0 * MW'(fwsr_pkg::GAIN_DIVISOR));
	assign quo = (rem >= MW'(fwsr_pkg::GAIN_DIVISOR)) ? q0 + 1'b1 : q0;

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			err_s1 <= err;
		end
		if (ctl.ld[1]) begin
			prod_s2 <= prod_full[PW-1:0];
		end
		if (ctl.ld[2]) begin
			mag_s3 <= mag;
			neg_s3 <= prod_s2[PW-1];
		end
		if (ctl.ld[3]) begin
			qprod_s4 <= mag_s3 * RECIP;
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
		end
		if (ctl.ld[4]) begin
			delta_s5 <= neg_s4 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
	end

	always_comb begin
		sum = $signed({{(DW-fwsr_pkg::DUTY_W){1'b0}}, duty_q});
		if (ctl.upd) begin
			sum = sum + $signed({delta_s5[MW], delta_s5});
		end
		if (sum < 0) begin
			duty_next = '0;
		end else if (sum >= $signed(DW'(fwsr_pkg::PWM_TOP))) begin
			duty_next = fwsr_pkg::PWM_TOP;
		end else begin
			duty_next = sum[fwsr_pkg::DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
		end else if (ctl.fire) begin
			duty_q <= duty_next;
		end
	end

endmodule

// ===== hw/rtl/fwsr_ctrl.sv =====
module fwsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_upd,
	input  logic                out_ready,
	output logic                in_ready,
	output fwsr_pkg::pipe_ctl_t ctl
);

	localparam int NS = fwsr_pkg::PIPE_STAGES;

	logic [NS:1]   v_q;
	logic [NS:1]   upd_q;
	logic [NS+1:1] rdy;

	// a stage can take an item when it is empty or its item moves on
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[1];

	always_comb begin
		ctl.ld[0] = in_valid && rdy[1];
		for (int k = 1; k < NS; k++) begin
			ctl.ld[k] = v_q[k] && rdy[k+1];
		end
		ctl.fire = v_q[NS] && out_ready;
		ctl.upd  = upd_q[NS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			upd_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1]   <= in_valid;
				upd_q[1] <= in_upd;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k]   <= v_q[k-1];
					upd_q[k] <= upd_q[k-1];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/fwsr_merge.sv =====
module fwsr_merge (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            fire,
	input  logic [fwsr_pkg::CHANNELS-1:0][fwsr_pkg::DUTY_W-1:0] duty,
	input  logic                                            m_tready,
	output logic                                            m_tvalid,
	output logic [fwsr_pkg::CHANNELS*fwsr_pkg::DUTY_W-1:0]  m_tdata,
	output logic                                            out_ready
);

	logic                                           valid_q;
	logic [fwsr_pkg::CHANNELS*fwsr_pkg::DUTY_W-1:0] data_q;

	assign out_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= fire;
		end
	end

	// channel zero in the lowest bits
	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= duty;
		end
	end

endmodule

// ===== hw/rtl/four_wheel_speed_regulator.sv =====
// Pipeline: an accepted item passes five lane stages for error, gain product, sign fold,
// reciprocal multiply and quotient correction, the first loaded at the accepting edge,
// then the duty accumulate into the output register that drives m_tvalid.
// Throughput: one item per cycle, stalled only by m_tready; one result per item.
// Reset: edge counts and duties clear to zero, registers take their defaults.
module four_wheel_speed_regulator #(
	parameter int COUNT_BITS = fwsr_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [3:0] pulse_mask
	input  logic                                s_tlast,  // tick
	input  logic                                s_tuser,  // run_enable
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [9:0] duty_zero, [19:10] duty_one, [29:20] duty_two, [39:30] duty_three
	output logic [39:0]                         m_tdata,
	input  logic                                cfg_we,
	input  logic [fwsr_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [fwsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CH = fwsr_pkg::CHANNELS;

	logic [fwsr_pkg::SP_W-1:0]       sp_left_q;
	logic [fwsr_pkg::SP_W-1:0]       sp_right_q;
	logic [fwsr_pkg::GAIN_W-1:0]     kp_q;
	logic [fwsr_pkg::GAIN_W-1:0]     ki_q;
	logic [fwsr_pkg::GAIN_W-1:0]     kd_q;
	logic [fwsr_pkg::GAIN_SUM_W-1:0] gain_sum_q;

	fwsr_pkg::pipe_ctl_t             ctl;
	logic                            out_ready;
	logic [CH-1:0][fwsr_pkg::DUTY_W-1:0] duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_left_q  <= fwsr_pkg::SP_LEFT_RST;
			sp_right_q <= fwsr_pkg::SP_RIGHT_RST;
			kp_q       <= fwsr_pkg::KP_RST;
			ki_q       <= fwsr_pkg::KI_RST;
			kd_q       <= fwsr_pkg::KD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwsr_pkg::REG_SP_LEFT:  sp_left_q  <= cfg_data[fwsr_pkg::SP_W-1:0];
				fwsr_pkg::REG_SP_RIGHT: sp_right_q <= cfg_data[fwsr_pkg::SP_W-1:0];
				fwsr_pkg::REG_KP:       kp_q       <= cfg_data;
				fwsr_pkg::REG_KI:       ki_q       <= cfg_data;
				fwsr_pkg::REG_KD:       kd_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// only the sum of the three gains is used; it is a register that follows the gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_sum_q <= fwsr_pkg::GAIN_SUM_W'(fwsr_pkg::KP_RST)
				+ fwsr_pkg::GAIN_SUM_W'(fwsr_pkg::KI_RST)
				+ fwsr_pkg::GAIN_SUM_W'(fwsr_pkg::KD_RST);
		end else begin
			gain_sum_q <= fwsr_pkg::GAIN_SUM_W'(kp_q) + fwsr_pkg::GAIN_SUM_W'(ki_q)
				+ fwsr_pkg::GAIN_SUM_W'(kd_q);
		end
	end

	fwsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_upd    (s_tlast && s_tuser),
		.out_ready (out_ready),
		.in_ready  (s_tready),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < CH; i++) begin : g_lane
		fwsr_lane #(
			.COUNT_BITS (COUNT_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pulse     (s_tdata[i]),
			.tick      (s_tlast),
			.setpoint  ((i % 2 == 0) ? sp_left_q : sp_right_q),
			.gain_sum  (gain_sum_q),
			.duty_next (duty[i])
		);
	end

	fwsr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (ctl.fire),
		.duty      (duty),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.out_ready (out_ready)
	);

endmodule

// ===== dv/four_wheel_speed_regulator_checker.sv =====
`timescale 1ns / 100ps

module four_wheel_speed_regulator_checker #(
	parameter int COUNT_BITS = fwsr_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [3:0] pulse_mask
	input  logic                                s_tlast,  // tick
	input  logic                                s_tuser,  // run_enable
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// [9:0] duty_zero, [19:10] duty_one, [29:20] duty_two, [39:30] duty_three
	input  logic [39:0]                         m_tdata,
	input  logic                                cfg_we,
	input  logic [fwsr_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [fwsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  outstanding
);

	localparam int CH = fwsr_pkg::CHANNELS;
	localparam int DW = fwsr_pkg::DUTY_W;
	localparam longint DUTY_SCALE = longint'(fwsr_pkg::GAIN_DIVISOR) << fwsr_pkg::Q_FRAC;

	logic [fwsr_pkg::SP_W-1:0]     sp_left;
	logic [fwsr_pkg::SP_W-1:0]     sp_right;
	logic [fwsr_pkg::GAIN_W-1:0]   kp;
	logic [fwsr_pkg::GAIN_W-1:0]   ki;
	logic [fwsr_pkg::GAIN_W-1:0]   kd;
	logic [COUNT_BITS-1:0]         edge_count [CH];
	logic [DW-1:0]                 duty_now [CH];
	logic [CH*DW-1:0]              expected_duties [$];
	logic [CH*DW-1:0]              want;
	logic [fwsr_pkg::SP_W-1:0]     target;

	function automatic logic [DW-1:0] updated_duty(input logic [DW-1:0] duty,
			input logic [fwsr_pkg::SP_W-1:0] sp, input logic [COUNT_BITS-1:0] cnt);
		longint gain_sum;
		longint speed_err;
		longint acc;
		longint quo;
		gain_sum  = longint'(kp) + longint'(ki) + longint'(kd);
		speed_err = longint'(sp) - longint'(cnt);
		acc       = longint'(duty) * DUTY_SCALE + speed_err * gain_sum;
		quo       = acc / DUTY_SCALE;
		// division truncates toward zero; pull negative remainders down
		if (acc % DUTY_SCALE != 0 && acc < 0)
			quo = quo - 1;
		if (quo < 0)
			quo = 0;
		if (quo > longint'(fwsr_pkg::PWM_TOP))
			quo = longint'(fwsr_pkg::PWM_TOP);
		return quo[DW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_left  = fwsr_pkg::SP_LEFT_RST;
			sp_right = fwsr_pkg::SP_RIGHT_RST;
			kp       = fwsr_pkg::KP_RST;
			ki       = fwsr_pkg::KI_RST;
			kd       = fwsr_pkg::KD_RST;
			for (int i = 0; i < CH; i++) begin
				edge_count[i] = '0;
				duty_now[i]   = '0;
			end
			expected_duties.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fwsr_pkg::REG_SP_LEFT: begin
						sp_left = cfg_data[fwsr_pkg::SP_W-1:0];
					end
					fwsr_pkg::REG_SP_RIGHT: begin
						sp_right = cfg_data[fwsr_pkg::SP_W-1:0];
					end
					fwsr_pkg::REG_KP: begin
						kp = cfg_data[fwsr_pkg::GAIN_W-1:0];
					end
					fwsr_pkg::REG_KI: begin
						ki = cfg_data[fwsr_pkg::GAIN_W-1:0];
					end
					fwsr_pkg::REG_KD: begin
						kd = cfg_data[fwsr_pkg::GAIN_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (s_tvalid && s_tready) begin
				// count this item's edges before any tick uses them
				for (int i = 0; i < CH; i++) begin
					if (s_tdata[i] && edge_count[i] != '1)
						edge_count[i] = edge_count[i] + 1'b1;
				end
				if (s_tlast) begin
					for (int i = 0; i < CH; i++) begin
						target = (i % 2 == 1) ? sp_right : sp_left;
						if (s_tuser)
							duty_now[i] = updated_duty(duty_now[i], target, edge_count[i]);
						edge_count[i] = '0;
					end
				end
				for (int i = 0; i < CH; i++)
					want[i*DW +: DW] = duty_now[i];
				expected_duties.push_back(want);
			end

			if (m_tvalid && m_tready) begin
				if (expected_duties.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result %h", $realtime, m_tdata);
				end else begin
					want = expected_duties.pop_front();
					for (int i = 0; i < CH; i++) begin
						if (m_tdata[i*DW +: DW] !== want[i*DW +: DW]) begin
							fail_count++;
							if (fail_count <= 10)
								$display("%0t: duty of channel %0d expected %0d, got %0d",
									$realtime, i, want[i*DW +: DW],
									m_tdata[i*DW +: DW]);
						end
					end
				end
			end
			outstanding = expected_duties.size();
		end
	end

endmodule

// ===== dv/four_wheel_speed_regulator_tb.sv =====
`timescale 1ns / 100ps

module four_wheel_speed_regulator_tb;

	localparam int ITEMS_RANDOM = 900;
	localparam int PHASES       = 10;
	localparam int EDGE_RUN     = 300;
	localparam int IW           = fwsr_pkg::REG_IDX_W;
	localparam int CW           = fwsr_pkg::CFG_DATA_W;
	localparam int SW           = fwsr_pkg::SP_W;
	localparam logic [IW-1:0] REG_FIRST_UNUSED = fwsr_pkg::REG_KD + 1'b1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [39:0]           m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [IW-1:0]         cfg_index = '0;
	logic [CW-1:0]         cfg_data  = '0;

	logic                  idle_on    = 1'b0;
	int                    stall_left = 0;
	int                    fail_count;
	int                    outstanding;

	four_wheel_speed_regulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	four_wheel_speed_regulator_checker duty_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure in short bursts while idle_on is set
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic [3:0] mask, input logic tick, input logic run);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {4'b0000, 4'($urandom)};
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, mask};
		s_tlast  <= tick;
		s_tuser  <= run;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and wait until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (fwsr_pkg::PIPE_STAGES + 2) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CW-1:0] sp_l, input logic [CW-1:0] sp_r,
			input logic [CW-1:0] gp, input logic [CW-1:0] gi,
			input logic [CW-1:0] gd);
		cfg_we    <= 1'b1;
		cfg_index <= fwsr_pkg::REG_SP_LEFT;
		cfg_data  <= sp_l;
		@(posedge clk);
		cfg_index <= fwsr_pkg::REG_SP_RIGHT;
		cfg_data  <= sp_r;
		@(posedge clk);
		cfg_index <= fwsr_pkg::REG_KP;
		cfg_data  <= gp;
		@(posedge clk);
		cfg_index <= fwsr_pkg::REG_KI;
		cfg_data  <= gi;
		@(posedge clk);
		cfg_index <= fwsr_pkg::REG_KD;
		cfg_data  <= gd;
		@(posedge clk);
		// unmapped index must leave everything alone
		cfg_index <= IW'($urandom_range((1 << IW) - 1, REG_FIRST_UNUSED));
		cfg_data  <= CW'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CW-1:0] pick_setpoint(input logic [SW-1:0] dflt);
		logic [SW-1:0] sp;
		case ($urandom_range(0, 4))
			0: sp = '0;
			1: sp = '1;
			2: sp = dflt;
			3: sp = SW'($urandom);
			default: sp = SW'($urandom_range(0, 40));
		endcase
		return {(CW - SW)'($urandom), sp};
	endfunction

	function automatic logic [CW-1:0] pick_gain(input logic [fwsr_pkg::GAIN_W-1:0] dflt);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return dflt;
			3: return CW'($urandom);
			default: return CW'($urandom_range(0, 8191));
		endcase
	endfunction

	initial begin
		int dens;
		int tick_odds;
		logic [3:0] mask;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: edges with tick, tick alone, run disabled
		send_item(4'hF, 1'b0, 1'b1);
		send_item(4'hF, 1'b0, 1'b1);
		send_item(4'hF, 1'b1, 1'b1);
		send_item(4'h0, 1'b1, 1'b1);
		send_item(4'hA, 1'b0, 1'b0);
		send_item(4'h5, 1'b1, 1'b0);
		send_item(4'h3, 1'b0, 1'b1);
		send_item(4'hC, 1'b1, 1'b1);
		wait_idle();

		// top targets and top gains drive every duty into the upper clamp
		program_regs(16'h00FF, 16'h00FF, '1, '1, '1);
		send_item(4'h0, 1'b1, 1'b1);
		send_item(4'h0, 1'b1, 1'b1);
		wait_idle();

		// zero targets pull the duties back down
		program_regs('0, '0, '1, '1, '1);
		repeat (12) send_item(4'hF, 1'b0, 1'b1);
		send_item(4'hF, 1'b1, 1'b1);
		send_item(4'h0, 1'b1, 1'b1);
		wait_idle();

		// long run of edges on every channel, then one tick lowers every duty
		program_regs('0, 16'h00FF, fwsr_pkg::KP_RST, fwsr_pkg::KI_RST, fwsr_pkg::KD_RST);
		idle_on <= 1'b1;
		repeat (EDGE_RUN) send_item(4'hF, 1'b0, 1'b1);
		send_item(4'hF, 1'b1, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			program_regs(pick_setpoint(fwsr_pkg::SP_LEFT_RST),
				pick_setpoint(fwsr_pkg::SP_RIGHT_RST),
				pick_gain(fwsr_pkg::KP_RST), pick_gain(fwsr_pkg::KI_RST),
				pick_gain(fwsr_pkg::KD_RST));
			idle_on   <= (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			dens      = $urandom_range(0, 100);
			tick_odds = $urandom_range(1, 40);
			repeat (ITEMS_RANDOM / PHASES) begin
				for (int b = 0; b < 4; b++)
					mask[b] = ($urandom_range(0, 99) < dens);
				send_item(mask, $urandom_range(1, tick_odds) == 1, $urandom_range(0, 7) != 0);
			end
		end
		wait_idle();

		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== four_wheel_speed_regulator.f =====
hw/rtl/fwsr_pkg.sv
hw/rtl/fwsr_lane.sv
hw/rtl/fwsr_ctrl.sv
hw/rtl/fwsr_merge.sv
hw/rtl/four_wheel_speed_regulator.sv
dv/four_wheel_speed_regulator_checker.sv
dv/four_wheel_speed_regulator_tb.sv
